[src/eit_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eit_pkg
// Shared constants for the edge interval timer: register indexes, widths
// and reset values of the control registers.
// ----------------------------------------------------------------------------
package eit_pkg;

   localparam int CounterBitsDefault = 16;

   // field widths
   localparam int TickW   = 16;
   localparam int UsecW   = 16;
   localparam int ValueW  = 24;
   localparam int ModeW   = 2;
   localparam int CsrIdxW = 3;
   localparam int CsrDataW = 24;

   // register indexes
   localparam logic [CsrIdxW-1:0] RegMeasureMode  = 3'd0;
   localparam logic [CsrIdxW-1:0] RegUsecMul      = 3'd1;
   localparam logic [CsrIdxW-1:0] RegUsecDiv      = 3'd2;
   localparam logic [CsrIdxW-1:0] RegFreqNum      = 3'd3;
   localparam logic [CsrIdxW-1:0] RegSpeedNum     = 3'd4;

   // measure modes
   localparam logic [ModeW-1:0] ModePeriodA  = 2'd0;
   localparam logic [ModeW-1:0] ModeAToB     = 2'd1;
   localparam logic [ModeW-1:0] ModeFreqA    = 2'd2;
   localparam logic [ModeW-1:0] ModeSpeedAB  = 2'd3;

   // reset values
   localparam logic [UsecW-1:0]  UsecMulReset  = 16'd125;
   localparam logic [UsecW-1:0]  UsecDivReset  = 16'd192;
   localparam logic [ValueW-1:0] FreqNumReset  = 24'd1000000;
   localparam logic [ValueW-1:0] SpeedNumReset = 24'd2237414;

endpackage

[src/edge_interval_timer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_interval_timer_core
// Tick-driven interval timer: stamps a rising edge on A, then a later edge
// on A or B, and converts the interval to microseconds and a derived rate.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  req     | in        | req_valid/stall    | start_req, pin_a, pin_b (one tick)
//  rsp     | out       | rsp_valid/stall    | elapsed_ticks, elapsed_usec,
//          |           |                    | derived_value, divide_error
//  csr     | in        | csr_write          | csr_index, csr_wdata
//
//  The tick of the closing edge starts a multiply step, then 32 divide
//  steps, plus 24 more in the frequency and speed modes when the
//  microsecond value is nonzero, then a load of the result register.
//  All divide steps run through one shared restoring-divide subtractor.
//  req_stall is high while that sequence runs and while its result waits
//  for a full result register. Reset is synchronous, active high.
//
module edge_interval_timer_core
   import eit_pkg::*;
#(
   parameter int COUNTER_BITS = CounterBitsDefault
) (
   input  logic                clock,
   input  logic                reset,
   // tick input
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_start_req,
   input  logic                req_pin_a,
   input  logic                req_pin_b,
   // result output
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [TickW-1:0]    rsp_elapsed_ticks,
   output logic [UsecW-1:0]    rsp_elapsed_usec,
   output logic [ValueW-1:0]   rsp_derived_value,
   output logic                rsp_divide_error,
   // register writes
   input  logic                csr_write,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   localparam int TW = (COUNTER_BITS < TickW) ? COUNTER_BITS : TickW;

   // phase codes
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_FIRST  = 2'd1;
   localparam logic [1:0] PH_SECOND = 2'd2;

   // sequencer codes
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_DIV1 = 3'd2;
   localparam logic [2:0] ST_DIV2 = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   localparam logic [4:0] DIV1_LAST = 5'd31;
   localparam logic [4:0] DIV2_LAST = 5'd23;

   // control registers
   logic [ModeW-1:0]  mode_ff;
   logic [UsecW-1:0]  usec_mul_ff;
   logic [UsecW-1:0]  usec_div_ff;
   logic [ValueW-1:0] freq_num_ff;
   logic [ValueW-1:0] speed_num_ff;

   // tick state
   logic [COUNTER_BITS-1:0] cnt_ff;
   logic [COUNTER_BITS-1:0] stamp_ff;
   logic [1:0]              phase_ff;
   logic                    last_a_ff;
   logic                    last_b_ff;

   // sequencer and shared divider
   logic [2:0]        state_ff;
   logic [4:0]        step_ff;
   logic [31:0]       quo_ff;
   logic [15:0]       rem_ff;
   logic [15:0]       dvs_ff;
   logic [TickW-1:0]  ticks_ff;
   logic [UsecW-1:0]  usec_ff;

   // result register
   logic              rsp_valid_ff;
   logic [TickW-1:0]  out_ticks_ff;
   logic [UsecW-1:0]  out_usec_ff;
   logic [ValueW-1:0] out_value_ff;
   logic              out_err_ff;

   logic                    tick_in;
   logic [COUNTER_BITS-1:0] cnt_in;
   logic [COUNTER_BITS-1:0] diff;
   logic                    rise_a;
   logic                    rise_b;
   logic                    second_hit;
   logic                    rate_mode;
   logic [16:0]             rem_shift;
   logic [17:0]             trial;
   logic                    fits;
   logic [15:0]             rem_in;
   logic [31:0]             quo_in;
   logic [UsecW-1:0]        usec_sat;
   logic                    out_free;

   assign tick_in    = req_valid && !req_stall;
   assign cnt_in     = cnt_ff + 1'b1;
   assign diff       = cnt_in - stamp_ff;
   assign rise_a     = req_pin_a && !last_a_ff;
   assign rise_b     = req_pin_b && !last_b_ff;
   assign rate_mode  = (mode_ff == ModeFreqA) || (mode_ff == ModeSpeedAB);
   assign second_hit = ((mode_ff == ModeAToB) || (mode_ff == ModeSpeedAB)) ? rise_b : rise_a;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // one restoring-divide step; a zero divisor yields all ones, which
   // saturates the microsecond value as required
   assign rem_shift = {rem_ff, quo_ff[31]};
   assign trial     = {1'b0, rem_shift} - {2'b00, dvs_ff};
   assign fits      = !trial[17];
   assign rem_in    = fits ? trial[15:0] : rem_shift[15:0];
   assign quo_in    = {quo_ff[30:0], fits};
   assign usec_sat  = (quo_in[31:16] != 16'd0) ? 16'hFFFF : quo_in[15:0];

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_elapsed_ticks = out_ticks_ff;
   assign rsp_elapsed_usec  = out_usec_ff;
   assign rsp_derived_value = out_value_ff;
   assign rsp_divide_error  = out_err_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= ModePeriodA;
         usec_mul_ff  <= UsecMulReset;
         usec_div_ff  <= UsecDivReset;
         freq_num_ff  <= FreqNumReset;
         speed_num_ff <= SpeedNumReset;
      end else if (csr_write) begin
         case (csr_index)
            RegMeasureMode: mode_ff      <= csr_wdata[ModeW-1:0];
            RegUsecMul:     usec_mul_ff  <= csr_wdata[UsecW-1:0];
            RegUsecDiv:     usec_div_ff  <= csr_wdata[UsecW-1:0];
            RegFreqNum:     freq_num_ff  <= csr_wdata[ValueW-1:0];
            RegSpeedNum:    speed_num_ff <= csr_wdata[ValueW-1:0];
            default: ;
         endcase
      end
   end

   // tick processing and sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         stamp_ff  <= '0;
         phase_ff  <= PH_IDLE;
         last_a_ff <= 1'b0;
         last_b_ff <= 1'b0;
         state_ff  <= ST_IDLE;
         step_ff   <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (tick_in) begin
                  last_a_ff <= req_pin_a;
                  last_b_ff <= req_pin_b;
                  if (req_start_req) begin
                     cnt_ff   <= '0;
                     phase_ff <= PH_FIRST;
                  end else begin
                     cnt_ff <= cnt_in;
                     case (phase_ff)
                        PH_FIRST: begin
                           if (rise_a) begin
                              stamp_ff <= cnt_in;
                              phase_ff <= PH_SECOND;
                           end
                        end
                        PH_SECOND: begin
                           if (second_hit) begin
                              ticks_ff <= TickW'(diff[TW-1:0]);
                              phase_ff <= PH_IDLE;
                              state_ff <= ST_MUL;
                           end
                        end
                        default: phase_ff <= PH_IDLE;
                     endcase
                  end
               end
            end
            ST_MUL: begin
               quo_ff   <= 32'(ticks_ff) * 32'(usec_mul_ff);
               rem_ff   <= '0;
               dvs_ff   <= usec_div_ff;
               step_ff  <= '0;
               state_ff <= ST_DIV1;
            end
            ST_DIV1: begin
               if ((step_ff == DIV1_LAST) && rate_mode && (usec_sat != 16'd0)) begin
                  usec_ff  <= usec_sat;
                  // numerator left-aligned: 24 steps leave the quotient low
                  quo_ff   <= {(mode_ff == ModeFreqA) ? freq_num_ff : speed_num_ff,
                               8'd0};
                  rem_ff   <= '0;
                  dvs_ff   <= usec_sat;
                  step_ff  <= '0;
                  state_ff <= ST_DIV2;
               end else begin
                  quo_ff  <= quo_in;
                  rem_ff  <= rem_in;
                  step_ff <= step_ff + 1'b1;
                  if (step_ff == DIV1_LAST) begin
                     usec_ff  <= usec_sat;
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_DIV2: begin
               quo_ff  <= quo_in;
               rem_ff  <= rem_in;
               step_ff <= step_ff + 1'b1;
               if (step_ff == DIV2_LAST) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
         out_ticks_ff <= ticks_ff;
         out_usec_ff  <= usec_ff;
         if (!rate_mode) begin
            out_value_ff <= ValueW'(usec_ff);
            out_err_ff   <= 1'b0;
         end else if (usec_ff == 16'd0) begin
            out_value_ff <= '0;
            out_err_ff   <= 1'b1;
         end else begin
            out_value_ff <= quo_ff[ValueW-1:0];
            out_err_ff   <= 1'b0;
         end
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // ---- assertions ----
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
      else $error("result beat raised outside completion");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_error) |->
         (rsp_derived_value == '0 && rsp_elapsed_usec == '0))
      else $error("divide error with nonzero value or usec");

   a_plain_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rate_mode) |->
         (rsp_derived_value == ValueW'(rsp_elapsed_usec) && !rsp_divide_error))
      else $error("derived value differs from usec in interval modes");

   a_div2_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV2) |-> (dvs_ff != 16'd0))
      else $error("second divide started with zero divisor");

endmodule

[verif/tb_edge_interval_timer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_edge_interval_timer_core
// Self-checking bench for the edge interval timer. A short table of ticks
// with hand-worked results opens the run. Random measurement sequences
// follow, with the register settings changed between phases. A behavioral
// timer model in this file predicts the other beats, and a scoreboard
// compares the beats field by field. Both handshakes see random gaps.
// ----------------------------------------------------------------------------
module tb_edge_interval_timer_core;
   import eit_pkg::*;

   localparam int DrainCycles = 64;    // longer than the divide sequence of a closing tick
   localparam int RandomTicks = 700;

   typedef struct packed {
      logic [TickW-1:0]  ticks;
      logic [UsecW-1:0]  usec;
      logic [ValueW-1:0] value;
      logic              err;
   } timer_result_type;

   typedef enum logic [1:0] {PhIdle, PhArmed, PhClosing} capture_phase_type;
   typedef enum logic {RowTick, RowWrite} row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic                st;
      logic                a;
      logic                b;
      logic                pinned;
      timer_result_type    want;
      logic [CsrIdxW-1:0]  idx;
      logic [CsrDataW-1:0] data;
   } tick_row_type;

   typedef struct packed {
      logic             pinned;
      timer_result_type want;
   } pin_entry_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_start_req = 1'b0;
   logic                req_pin_a = 1'b0;
   logic                req_pin_b = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [TickW-1:0]    rsp_elapsed_ticks;
   logic [UsecW-1:0]    rsp_elapsed_usec;
   logic [ValueW-1:0]   rsp_derived_value;
   logic                rsp_divide_error;
   logic                csr_write = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;

   // timer model state and its copy of the registers
   logic [CounterBitsDefault-1:0] tick_cnt = '0;
   logic [CounterBitsDefault-1:0] edge_stamp = '0;
   capture_phase_type             cap_phase = PhIdle;
   logic                          lvl_a = 1'b0;
   logic                          lvl_b = 1'b0;
   logic [ModeW-1:0]              cfg_mode = ModePeriodA;
   logic [UsecW-1:0]              cfg_mul = UsecMulReset;
   logic [UsecW-1:0]              cfg_div = UsecDivReset;
   logic [ValueW-1:0]             cfg_freq_num = FreqNumReset;
   logic [ValueW-1:0]             cfg_speed_num = SpeedNumReset;

   timer_result_type expect_q[$];
   pin_entry_type    pin_q[$];
   tick_row_type     dir_rows[$];

   int  mismatches = 0;
   int  results_seen = 0;
   int  beats_taken = 0;
   int  stim_items = 0;
   int  settings_used = 0;
   int  hold_cnt = 0;
   bit  tx_calm = 0;
   bit  rx_calm = 0;

   edge_interval_timer_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_start_req     (req_start_req),
      .req_pin_a         (req_pin_a),
      .req_pin_b         (req_pin_b),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_elapsed_ticks (rsp_elapsed_ticks),
      .rsp_elapsed_usec  (rsp_elapsed_usec),
      .rsp_derived_value (rsp_derived_value),
      .rsp_divide_error  (rsp_divide_error),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("edge_interval_timer_core verification failed");
      $finish;
   end

   // One tick of the timer model; returns 1 when the tick closes a measurement.
   function automatic bit timer_tick(input logic st, input logic a, input logic b,
                                     output timer_result_type res);
      logic             rise_a;
      logic             rise_b;
      logic             close;
      logic [TickW-1:0] span;
      logic [31:0]      prod;
      logic [31:0]      quot;
      logic [ValueW-1:0] num;
      bit               got;
      got = 0;
      res = '0;
      if (st) begin
         tick_cnt  = '0;
         cap_phase = PhArmed;
         lvl_a     = a;
         lvl_b     = b;
         return 0;
      end
      tick_cnt = tick_cnt + 1'b1;
      rise_a = a & ~lvl_a;
      rise_b = b & ~lvl_b;
      case (cap_phase)
         PhArmed: begin
            if (rise_a) begin
               edge_stamp = tick_cnt;
               cap_phase  = PhClosing;
            end
         end
         PhClosing: begin
            close = (cfg_mode == ModeAToB || cfg_mode == ModeSpeedAB) ? rise_b : rise_a;
            if (close) begin
               span = TickW'(tick_cnt - edge_stamp);
               if (cfg_div == '0) begin
                  res.usec = '1;
               end else begin
                  prod = 32'(span) * 32'(cfg_mul);
                  quot = prod / 32'(cfg_div);
                  res.usec = (quot > 32'hFFFF) ? '1 : quot[UsecW-1:0];
               end
               res.ticks = span;
               if (cfg_mode == ModeFreqA || cfg_mode == ModeSpeedAB) begin
                  num = (cfg_mode == ModeFreqA) ? cfg_freq_num : cfg_speed_num;
                  if (res.usec == '0) begin
                     res.value = '0;
                     res.err   = 1'b1;
                  end else begin
                     res.value = num / ValueW'(res.usec);
                  end
               end else begin
                  res.value = ValueW'(res.usec);
               end
               got = 1;
               cap_phase = PhIdle;
            end
         end
         default: cap_phase = PhIdle;
      endcase
      lvl_a = a;
      lvl_b = b;
      return got;
   endfunction

   function automatic void check_field(input string name, input int unsigned exp_v,
                                       input int unsigned got_v);
      if (exp_v != got_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, got_v);
         mismatches++;
      end
   endfunction

   // scoreboard: predict on every accepted tick beat, check every result beat
   always @(posedge clock) begin : scoreboard
      timer_result_type pred;
      timer_result_type want;
      pin_entry_type    pin;
      bit               made;
      if (!reset && req_valid && !req_stall) begin
         made = timer_tick(req_start_req, req_pin_a, req_pin_b, pred);
         beats_taken++;
         pin = (pin_q.size() != 0) ? pin_q.pop_front() : '0;
         if (pin.pinned)
            expect_q.push_back(pin.want);
         else if (made)
            expect_q.push_back(pred);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expect_q.size() == 0) begin
            $error("result beat with nothing expected: elapsed_ticks %0d", rsp_elapsed_ticks);
            mismatches++;
         end else begin
            want = expect_q.pop_front();
            check_field("elapsed_ticks", 32'(want.ticks), 32'(rsp_elapsed_ticks));
            check_field("elapsed_usec", 32'(want.usec), 32'(rsp_elapsed_usec));
            check_field("derived_value", 32'(want.value), 32'(rsp_derived_value));
            check_field("divide_error", 32'(want.err), 32'(rsp_divide_error));
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // result-side backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cnt != 0) begin
         hold_cnt--;
      end else if (rx_calm || $urandom_range(0, 2) != 0) begin
         rsp_stall <= 1'b0;
         hold_cnt = $urandom_range(1, 8);
      end else begin
         rsp_stall <= 1'b1;
         hold_cnt = pick_gap() + 1;
      end
   end

   task automatic send_tick(input logic st, input logic a, input logic b);
      int gap;
      gap = tx_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_start_req <= st;
      req_pin_a     <= a;
      req_pin_b     <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // sender holds off until every result is back and the divider is quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (expect_q.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         RegMeasureMode: cfg_mode      = data[ModeW-1:0];
         RegUsecMul:     cfg_mul       = data[UsecW-1:0];
         RegUsecDiv:     cfg_div       = data[UsecW-1:0];
         RegFreqNum:     cfg_freq_num  = data[ValueW-1:0];
         RegSpeedNum:    cfg_speed_num = data[ValueW-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [CsrDataW-1:0] pick_value(input int bits, input bit zero_ok);
      int unsigned top;
      int          r;
      top = (32'd1 << bits) - 1;
      r = $urandom_range(0, 99);
      if (r < 10) return (zero_ok && r < 4) ? '0 : CsrDataW'(1);
      if (r < 22) return CsrDataW'(top);
      if (r < 60) return CsrDataW'($urandom_range(1, 1000));
      return CsrDataW'($urandom_range(1, top));
   endfunction

   task automatic reprogram();
      settle();
      write_reg(RegMeasureMode, CsrDataW'($urandom_range(0, 3)));
      write_reg(RegUsecMul, pick_value(UsecW, 0));
      write_reg(RegUsecDiv, pick_value(UsecW, 1));
      write_reg(RegFreqNum, pick_value(ValueW, 0));
      write_reg(RegSpeedNum, pick_value(ValueW, 0));
      settings_used++;
   endtask

   // start, first A edge, hold the closing pin low for the span, then close
   task automatic run_measurement(input int forced_span);
      int span;
      int r;
      int lead;
      bit on_b;
      bit keep_calm;
      on_b = (cfg_mode == ModeAToB || cfg_mode == ModeSpeedAB);
      r = $urandom_range(0, 99);
      if (forced_span > 0)
         span = forced_span;
      else if (r < 70)
         span = $urandom_range(1, 8);
      else if (r < 95)
         span = $urandom_range(9, 40);
      else
         span = $urandom_range(41, 150);
      if (!on_b && span < 2) span = 2;
      keep_calm = tx_calm;
      lead = $urandom_range(0, 2);
      send_tick(1'b1, 1'b0, 1'($urandom_range(0, 1)));
      repeat (lead) send_tick(1'b0, 1'b0, 1'($urandom_range(0, 1)));
      send_tick(1'b0, 1'b1, 1'($urandom_range(0, 1)));
      if (span > 8) tx_calm = 1;
      repeat (span - 1) begin
         // a rare stray start abandons the measurement
         if ($urandom_range(0, 49) == 0)
            send_tick(1'b1, 1'b0, 1'b0);
         else if (on_b)
            send_tick(1'b0, 1'($urandom_range(0, 1)), 1'b0);
         else
            send_tick(1'b0, 1'b0, 1'($urandom_range(0, 1)));
      end
      tx_calm = keep_calm;
      if (on_b)
         send_tick(1'b0, 1'($urandom_range(0, 1)), 1'b1);
      else
         send_tick(1'b0, 1'b1, 1'($urandom_range(0, 1)));
      stim_items += 2 + lead + span;
   endtask

   function automatic tick_row_type tick_row(input logic st, input logic a, input logic b);
      tick_row_type row;
      row = '0;
      row.kind = RowTick;
      row.st = st;
      row.a = a;
      row.b = b;
      return row;
   endfunction

   function automatic tick_row_type pin_row(input logic st, input logic a, input logic b,
                                            input int unsigned ticks, input int unsigned usec,
                                            input int unsigned value, input logic err);
      tick_row_type row;
      row = tick_row(st, a, b);
      row.pinned = 1'b1;
      row.want.ticks = TickW'(ticks);
      row.want.usec = UsecW'(usec);
      row.want.value = ValueW'(value);
      row.want.err = err;
      return row;
   endfunction

   function automatic tick_row_type reg_row(input logic [CsrIdxW-1:0] idx,
                                            input logic [CsrDataW-1:0] data);
      tick_row_type row;
      row = '0;
      row.kind = RowWrite;
      row.idx = idx;
      row.data = data;
      return row;
   endfunction

   initial begin : stimulus
      pin_entry_type pin;
      int            n;
      int            directed_ticks;

      // reset registers: A edge while idle is ignored, then a plain A period
      dir_rows.push_back(tick_row(1, 1, 0) ^ tick_row(1, 0, 0) ^ tick_row(0, 0, 0));
      dir_rows.push_back(tick_row(1, 0, 0));
      dir_rows.push_back(tick_row(0, 1, 0));
      dir_rows.push_back(tick_row(0, 0, 0));
      dir_rows.push_back(pin_row(0, 1, 0, 2, 1, 1, 0));
      // frequency mode with zero microseconds: divide error
      dir_rows.push_back(reg_row(RegMeasureMode, CsrDataW'(ModeFreqA)));
      dir_rows.push_back(reg_row(RegUsecMul, CsrDataW'(1)));
      dir_rows.push_back(tick_row(1, 0, 0));
      dir_rows.push_back(tick_row(0, 1, 0));
      dir_rows.push_back(tick_row(0, 0, 0));
      dir_rows.push_back(pin_row(0, 1, 0, 2, 0, 0, 1));
      // speed mode, zero divisor register saturates microseconds
      dir_rows.push_back(reg_row(RegMeasureMode, CsrDataW'(ModeSpeedAB)));
      dir_rows.push_back(reg_row(RegUsecMul, CsrDataW'(16'hFFFF)));
      dir_rows.push_back(reg_row(RegUsecDiv, CsrDataW'(0)));
      dir_rows.push_back(tick_row(1, 0, 1));
      dir_rows.push_back(tick_row(0, 1, 1));
      dir_rows.push_back(tick_row(0, 1, 0));
      dir_rows.push_back(pin_row(0, 0, 1, 2, 65535, 34, 0));
      // A to B with the product over the 16-bit limit; numerators at maximum
      dir_rows.push_back(reg_row(RegUsecDiv, CsrDataW'(1)));
      dir_rows.push_back(reg_row(RegMeasureMode, CsrDataW'(ModeAToB)));
      dir_rows.push_back(reg_row(RegFreqNum, CsrDataW'(24'hFFFFFF)));
      dir_rows.push_back(reg_row(RegSpeedNum, CsrDataW'(24'hFFFFFF)));
      dir_rows.push_back(tick_row(1, 0, 0));
      dir_rows.push_back(tick_row(0, 1, 1));
      dir_rows.push_back(tick_row(0, 0, 0));
      dir_rows.push_back(pin_row(0, 0, 1, 2, 65535, 65535, 0));
      // mode switched to frequency after the first A edge, before the closing one
      dir_rows.push_back(tick_row(1, 0, 0));
      dir_rows.push_back(tick_row(0, 1, 0));
      dir_rows.push_back(reg_row(RegMeasureMode, CsrDataW'(ModeFreqA)));
      dir_rows.push_back(tick_row(0, 0, 1));
      dir_rows.push_back(tick_row(0, 1, 0));
      // start after the first A edge abandons the measurement and rearms
      dir_rows.push_back(tick_row(1, 0, 0));
      dir_rows.push_back(tick_row(0, 1, 0));
      dir_rows.push_back(tick_row(1, 1, 0));
      dir_rows.push_back(tick_row(0, 0, 0));
      dir_rows.push_back(tick_row(0, 1, 0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      directed_ticks = 0;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == RowWrite) begin
            settle();
            write_reg(dir_rows[i].idx, dir_rows[i].data);
         end else begin
            pin.pinned = dir_rows[i].pinned;
            pin.want = dir_rows[i].want;
            pin_q.push_back(pin);
            send_tick(dir_rows[i].st, dir_rows[i].a, dir_rows[i].b);
            directed_ticks++;
         end
      end

      while (stim_items < RandomTicks) begin
         reprogram();
         tx_calm = ($urandom_range(0, 4) == 0);
         rx_calm = ($urandom_range(0, 4) == 0);
         repeat ($urandom_range(4, 8)) begin
            if ($urandom_range(0, 5) == 0) begin
               n = $urandom_range(4, 16);
               repeat (n)
                  send_tick(1'($urandom_range(0, 9) == 0), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
               stim_items += n;
            end else begin
               run_measurement(0);
            end
         end
      end

      settle();
      $display("%0d tick beats (%0d directed), %0d results checked, %0d random settings",
               beats_taken, directed_ticks, results_seen, settings_used);
      $display("%0d field mismatches", mismatches);
      if (mismatches == 0)
         $display("edge_interval_timer_core verification clean");
      else
         $display("edge_interval_timer_core verification failed");
      $finish;
   end

endmodule
